>>> src/epcc_pkg.sv
// Shared types, widths and helper functions of the edge point coverage check.
`default_nettype none

package epcc_pkg;

    localparam int COORD_W      = 24;
    localparam int BIN_W        = 7;
    localparam int DIST_W       = 20;
    localparam int CFG_W        = 24;
    localparam int IDX_W        = 3;
    localparam int MAX_BINS_DEF = 64;
    localparam int QDEPTH       = 2;
    localparam int IN_DATA_W    = 2 * COORD_W;
    localparam int OUT_DATA_W   = 8;

    localparam int MUL_W     = 26;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int LV_W      = 51;
    localparam int MAG_W     = 49;
    localparam int MAG_LO_W  = 25;
    localparam int NORM_W    = 49;
    localparam int NORM_LO_W = 25;
    localparam int M2_W      = 2 * DIST_W;
    localparam int M2_LO_W   = DIST_W;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int NUM_W     = COORD_W + BIN_W;
    localparam int QUO_W     = BIN_W;

    // coverage ratio 1.5 as 3/2
    localparam int COV_NUM = 3;
    localparam int COV_DEN = 2;

    localparam logic [IDX_W-1:0] REG_END0_X    = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_END0_Y    = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_END1_X    = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_END1_Y    = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_BIN_COUNT = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_MAX_DIST  = IDX_W'(5);

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic [BIN_W-1:0]          eff_bins;
        logic [DIST_W-1:0]         max_dist;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      last;
        logic                      bin_ok;
        logic [COORD_W-1:0]        d;
        logic [COORD_W-1:0]        len;
    } qent_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_TEST,
        ST_DIV,
        ST_MARK,
        ST_EMIT
    } back_state_t;

    function automatic logic [COORD_W:0] sdiff(input logic [COORD_W-1:0] u,
                                               input logic [COORD_W-1:0] v);
        sdiff = {u[COORD_W-1], u} - {v[COORD_W-1], v};
    endfunction

    function automatic logic [COORD_W-1:0] abs_of(input logic [COORD_W:0] s);
        logic [COORD_W:0] neg;
        neg = -s;
        abs_of = s[COORD_W] ? neg[COORD_W-1:0] : s[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> src/epcc_queue.sv
// Short item queue between the classifying front and the arithmetic back.
`default_nettype none

module epcc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire epcc_pkg::qent_t push_entry,
    output logic                 full,
    input  wire logic            pop,
    output logic                 valid,
    output epcc_pkg::qent_t      entry
);
    import epcc_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    qent_t            mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full  = (cnt_reg == CNT_W'(QDEPTH));
    assign valid = (cnt_reg != '0);
    assign entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> src/epcc_front.sv
// Input side: accept points and classify them against the edge extent.
`default_nettype none

module epcc_front (
    input  wire epcc_pkg::cfg_t                 cfg,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [epcc_pkg::IN_DATA_W-1:0] s_tdata,  // point_x, point_y
    input  wire logic                           s_tlast,  // last_point
    input  wire logic                           q_full,
    output logic                                q_push,
    output epcc_pkg::qent_t                     q_entry
);
    import epcc_pkg::*;

    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [COORD_W:0]          a;
    logic [COORD_W:0]          b;
    logic [COORD_W-1:0]        ua;
    logic [COORD_W-1:0]        ub;
    logic                      use_x;
    logic [COORD_W-1:0]        len;
    logic [COORD_W-1:0]        lo_x;
    logic [COORD_W-1:0]        lo_y;
    logic [COORD_W-1:0]        p;
    logic [COORD_W-1:0]        lo;
    logic [COORD_W:0]          diff;

    always_comb
    begin
        px    = s_tdata[COORD_W-1:0];
        py    = s_tdata[2*COORD_W-1:COORD_W];
        a     = sdiff(cfg.y1, cfg.y0);
        b     = sdiff(cfg.x0, cfg.x1);
        ua    = abs_of(a);
        ub    = abs_of(b);
        use_x = (ub > ua);
        len   = use_x ? ub : ua;
        lo_x  = ($signed(cfg.x0) < $signed(cfg.x1)) ? cfg.x0 : cfg.x1;
        lo_y  = ($signed(cfg.y0) < $signed(cfg.y1)) ? cfg.y0 : cfg.y1;
        p     = use_x ? px : py;
        lo    = use_x ? lo_x : lo_y;
        diff  = sdiff(p, lo);

        q_entry.px     = px;
        q_entry.py     = py;
        q_entry.last   = s_tlast;
        q_entry.d      = diff[COORD_W-1:0];
        q_entry.len    = len;
        q_entry.bin_ok = (cfg.eff_bins != '0) && (len != '0) && !diff[COORD_W]
                         && (diff[COORD_W-1:0] < len);
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

`default_nettype wire

>>> src/epcc_back.sv
// Back end: distance test on a shared multiplier, bin divide, bin map and result.
`default_nettype none

module epcc_back #(
    parameter int MAX_BINS = epcc_pkg::MAX_BINS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire epcc_pkg::cfg_t                  cfg,
    input  wire logic                            q_valid,
    input  wire epcc_pkg::qent_t                 q_entry,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [epcc_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import epcc_pkg::*;

    localparam int IW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int DCW = $clog2(QUO_W);

    localparam logic [3:0] S_X1Y0  = 4'd0;
    localparam logic [3:0] S_X0Y1  = 4'd1;
    localparam logic [3:0] S_APX   = 4'd2;
    localparam logic [3:0] S_BPY   = 4'd3;
    localparam logic [3:0] S_UA2   = 4'd4;
    localparam logic [3:0] S_UB2   = 4'd5;
    localparam logic [3:0] S_MD2   = 4'd6;
    localparam logic [3:0] S_MLL   = 4'd7;
    localparam logic [3:0] S_MLH   = 4'd8;
    localparam logic [3:0] S_MHH   = 4'd9;
    localparam logic [3:0] S_RLL   = 4'd10;
    localparam logic [3:0] S_RLH   = 4'd11;
    localparam logic [3:0] S_RHL   = 4'd12;
    localparam logic [3:0] S_RHH   = 4'd13;
    localparam logic [3:0] S_DNB   = 4'd14;
    localparam logic [3:0] S_DRAIN = 4'd15;

    back_state_t               state_reg;
    back_state_t               state_next;
    logic [3:0]                step_reg;
    logic [3:0]                step_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic [3:0]                prod_tag_reg;
    logic [3:0]                prod_tag_next;
    logic                      prod_vld_reg;
    logic                      prod_vld_next;

    qent_t                     item_reg;
    qent_t                     item_next;
    logic signed [LV_W-1:0]    c_reg;
    logic signed [LV_W-1:0]    c_next;
    logic signed [LV_W-1:0]    lv_reg;
    logic signed [LV_W-1:0]    lv_next;
    logic [NORM_W-1:0]         norm_reg;
    logic [NORM_W-1:0]         norm_next;
    logic [M2_W-1:0]           m2_reg;
    logic [M2_W-1:0]           m2_next;
    logic [SQ_W-1:0]           sql_reg;
    logic [SQ_W-1:0]           sql_next;
    logic [SQ_W-1:0]           sqr_reg;
    logic [SQ_W-1:0]           sqr_next;
    logic [NUM_W-1:0]          num_reg;
    logic [NUM_W-1:0]          num_next;
    logic [NUM_W-1:0]          div_rem_reg;
    logic [NUM_W-1:0]          div_rem_next;
    logic [QUO_W-1:0]          quo_reg;
    logic [QUO_W-1:0]          quo_next;
    logic [DCW-1:0]            div_cnt_reg;
    logic [DCW-1:0]            div_cnt_next;
    logic [MAX_BINS-1:0]       bin_seen_reg;
    logic [MAX_BINS-1:0]       bin_seen_next;
    logic [BIN_W-1:0]          count_reg;
    logic [BIN_W-1:0]          count_next;
    logic                      m_tvalid_reg;
    logic                      m_tvalid_next;
    logic [OUT_DATA_W-1:0]     m_tdata_reg;
    logic [OUT_DATA_W-1:0]     m_tdata_next;

    logic [COORD_W:0]          a;
    logic [COORD_W:0]          b;
    logic [COORD_W-1:0]        ua;
    logic [COORD_W-1:0]        ub;
    logic [LV_W-1:0]           lv_neg;
    logic [LV_W-1:0]           lv_abs;
    logic [MAG_W-1:0]          mag;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic                      issue;
    logic                      near;
    logic                      out_free;
    logic [NUM_W-1:0]          trial;
    logic [IW-1:0]             bin_idx;
    logic [BIN_W+1:0]          cov_lhs;
    logic [BIN_W+1:0]          cov_rhs;

    always_comb
    begin
        a        = sdiff(cfg.y1, cfg.y0);
        b        = sdiff(cfg.x0, cfg.x1);
        ua       = abs_of(a);
        ub       = abs_of(b);
        lv_neg   = -lv_reg;
        lv_abs   = lv_reg[LV_W-1] ? lv_neg : lv_reg;
        mag      = lv_abs[MAG_W-1:0];
        near     = (sql_reg < sqr_reg);
        out_free = !m_tvalid_reg || m_tready;
        trial    = NUM_W'(item_reg.len) << div_cnt_reg;
        bin_idx  = IW'(quo_reg);
        cov_lhs  = (BIN_W+2)'(count_reg) * (BIN_W+2)'(COV_NUM);
        cov_rhs  = (BIN_W+2)'(cfg.eff_bins) * (BIN_W+2)'(COV_DEN);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (step_reg == S_DRAIN)
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (near && item_reg.bin_ok)
                begin
                    state_next = ST_DIV;
                end
                else if (item_reg.last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                state_next = item_reg.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        q_pop         = 1'b0;
        step_next     = step_reg;
        item_next     = item_reg;
        c_next        = c_reg;
        lv_next       = lv_reg;
        norm_next     = norm_reg;
        m2_next       = m2_reg;
        sql_next      = sql_reg;
        sqr_next      = sqr_reg;
        num_next      = num_reg;
        div_rem_next  = div_rem_reg;
        quo_next      = quo_reg;
        div_cnt_next  = div_cnt_reg;
        bin_seen_next = bin_seen_reg;
        count_next    = count_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;

        issue = (state_reg == ST_MUL) && (step_reg != S_DRAIN);
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            S_X1Y0:
            begin
                mul_a = MUL_W'(cfg.x1);
                mul_b = MUL_W'(cfg.y0);
            end
            S_X0Y1:
            begin
                mul_a = MUL_W'(cfg.x0);
                mul_b = MUL_W'(cfg.y1);
            end
            S_APX:
            begin
                mul_a = MUL_W'($signed(a));
                mul_b = MUL_W'(item_reg.px);
            end
            S_BPY:
            begin
                mul_a = MUL_W'($signed(b));
                mul_b = MUL_W'(item_reg.py);
            end
            S_UA2:
            begin
                mul_a = MUL_W'(ua);
                mul_b = MUL_W'(ua);
            end
            S_UB2:
            begin
                mul_a = MUL_W'(ub);
                mul_b = MUL_W'(ub);
            end
            S_MD2:
            begin
                mul_a = MUL_W'(cfg.max_dist);
                mul_b = MUL_W'(cfg.max_dist);
            end
            S_MLL:
            begin
                mul_a = MUL_W'(mag[MAG_LO_W-1:0]);
                mul_b = MUL_W'(mag[MAG_LO_W-1:0]);
            end
            S_MLH:
            begin
                mul_a = MUL_W'(mag[MAG_LO_W-1:0]);
                mul_b = MUL_W'(mag[MAG_W-1:MAG_LO_W]);
            end
            S_MHH:
            begin
                mul_a = MUL_W'(mag[MAG_W-1:MAG_LO_W]);
                mul_b = MUL_W'(mag[MAG_W-1:MAG_LO_W]);
            end
            S_RLL:
            begin
                mul_a = MUL_W'(m2_reg[M2_LO_W-1:0]);
                mul_b = MUL_W'(norm_reg[NORM_LO_W-1:0]);
            end
            S_RLH:
            begin
                mul_a = MUL_W'(m2_reg[M2_LO_W-1:0]);
                mul_b = MUL_W'(norm_reg[NORM_W-1:NORM_LO_W]);
            end
            S_RHL:
            begin
                mul_a = MUL_W'(m2_reg[M2_W-1:M2_LO_W]);
                mul_b = MUL_W'(norm_reg[NORM_LO_W-1:0]);
            end
            S_RHH:
            begin
                mul_a = MUL_W'(m2_reg[M2_W-1:M2_LO_W]);
                mul_b = MUL_W'(norm_reg[NORM_W-1:NORM_LO_W]);
            end
            S_DNB:
            begin
                mul_a = MUL_W'(item_reg.d);
                mul_b = MUL_W'(cfg.eff_bins);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next     = mul_a * mul_b;
        prod_vld_next = issue;
        prod_tag_next = step_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_entry;
                    step_next = S_X1Y0;
                end
            end
            ST_MUL:
            begin
                if (step_reg != S_DRAIN)
                begin
                    step_next = step_reg + 1'b1;
                end
                if (prod_vld_reg)
                begin
                    case (prod_tag_reg)
                        S_X1Y0: c_next    = LV_W'(prod_reg);
                        S_X0Y1: c_next    = c_reg - LV_W'(prod_reg);
                        S_APX:  lv_next   = c_reg + LV_W'(prod_reg);
                        S_BPY:  lv_next   = lv_reg + LV_W'(prod_reg);
                        S_UA2:  norm_next = NORM_W'(prod_reg);
                        S_UB2:  norm_next = norm_reg + NORM_W'(prod_reg);
                        S_MD2:  m2_next   = M2_W'(prod_reg);
                        S_MLL:  sql_next  = SQ_W'(prod_reg[PROD_W-3:0]);
                        S_MLH:  sql_next  = sql_reg
                                            + (SQ_W'(prod_reg[PROD_W-3:0]) << (MAG_LO_W + 1));
                        S_MHH:  sql_next  = sql_reg
                                            + (SQ_W'(prod_reg[PROD_W-3:0]) << (2 * MAG_LO_W));
                        S_RLL:  sqr_next  = SQ_W'(prod_reg[PROD_W-3:0]);
                        S_RLH:  sqr_next  = sqr_reg
                                            + (SQ_W'(prod_reg[PROD_W-3:0]) << NORM_LO_W);
                        S_RHL:  sqr_next  = sqr_reg
                                            + (SQ_W'(prod_reg[PROD_W-3:0]) << M2_LO_W);
                        S_RHH:  sqr_next  = sqr_reg
                                            + (SQ_W'(prod_reg[PROD_W-3:0])
                                               << (M2_LO_W + NORM_LO_W));
                        S_DNB:  num_next  = NUM_W'(prod_reg);
                        default:
                        begin
                            num_next = num_reg;
                        end
                    endcase
                end
            end
            ST_TEST:
            begin
                div_rem_next = num_reg;
                quo_next     = '0;
                div_cnt_next = DCW'(QUO_W - 1);
            end
            ST_DIV:
            begin
                if (div_rem_reg >= trial)
                begin
                    div_rem_next          = div_rem_reg - trial;
                    quo_next[div_cnt_reg] = 1'b1;
                end
                div_cnt_next = div_cnt_reg - 1'b1;
            end
            ST_MARK:
            begin
                if (!bin_seen_reg[bin_idx])
                begin
                    bin_seen_next[bin_idx] = 1'b1;
                    count_next             = count_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {count_reg, cov_lhs > cov_rhs};
                    bin_seen_next = '0;
                    count_next    = '0;
                end
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= S_X1Y0;
            prod_vld_reg <= 1'b0;
            bin_seen_reg <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            prod_vld_reg <= prod_vld_next;
            bin_seen_reg <= bin_seen_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        prod_tag_reg <= prod_tag_next;
        item_reg     <= item_next;
        c_reg        <= c_next;
        lv_reg       <= lv_next;
        norm_reg     <= norm_next;
        m2_reg       <= m2_next;
        sql_reg      <= sql_next;
        sqr_reg      <= sqr_next;
        num_reg      <= num_next;
        div_rem_reg  <= div_rem_next;
        quo_reg      <= quo_next;
        div_cnt_reg  <= div_cnt_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> src/edge_point_coverage_check.sv
// Top level: configuration registers, front classifier, item queue and back end.
`default_nettype none

// Points of one cloud enter on the s_ stream, one per item, and are tested against the
// line through the two configured edge endpoints; near points are binned along the edge's
// longer axis and each occupied bin is counted once. The item flagged by s_tlast yields one
// result on the m_ stream (coverage flag and occupied bin count) and clears the bin map.
// A point passes through the back end in order: a pick-up step, a sequence of products
// on the single 26x26 signed multiplier, a test step and, when it is binned, seven divide
// steps and one bin update; a last point then adds an emit step that loads the output
// register and waits while it is held by m_tready. A two-item queue lets the input side
// keep taking points while the back end works. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block does not enforce this.

module edge_point_coverage_check #(
    parameter int MAX_BINS = epcc_pkg::MAX_BINS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [epcc_pkg::IN_DATA_W-1:0]  s_tdata,   // point_x, point_y
    input  wire logic                            s_tlast,   // last_point
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [epcc_pkg::OUT_DATA_W-1:0]      m_tdata,   // coverage_ok, occupied_bins
    input  wire logic                            cfg_we,
    input  wire logic [epcc_pkg::IDX_W-1:0]      cfg_index,
    input  wire logic [epcc_pkg::CFG_W-1:0]      cfg_data
);
    import epcc_pkg::*;

    logic [COORD_W-1:0] cfg_x0_reg;
    logic [COORD_W-1:0] cfg_y0_reg;
    logic [COORD_W-1:0] cfg_x1_reg;
    logic [COORD_W-1:0] cfg_y1_reg;
    logic [BIN_W-1:0]   cfg_bins_reg;
    logic [DIST_W-1:0]  cfg_dist_reg;

    cfg_t  cfg_s;
    logic  q_full;
    logic  q_push;
    qent_t q_push_entry;
    logic  q_pop;
    logic  q_valid;
    qent_t q_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_x0_reg   <= '0;
            cfg_y0_reg   <= '0;
            cfg_x1_reg   <= '0;
            cfg_y1_reg   <= '0;
            cfg_bins_reg <= BIN_W'(10);
            cfg_dist_reg <= DIST_W'(102);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_END0_X:    cfg_x0_reg   <= cfg_data[COORD_W-1:0];
                REG_END0_Y:    cfg_y0_reg   <= cfg_data[COORD_W-1:0];
                REG_END1_X:    cfg_x1_reg   <= cfg_data[COORD_W-1:0];
                REG_END1_Y:    cfg_y1_reg   <= cfg_data[COORD_W-1:0];
                REG_BIN_COUNT: cfg_bins_reg <= cfg_data[BIN_W-1:0];
                REG_MAX_DIST:  cfg_dist_reg <= cfg_data[DIST_W-1:0];
                default:
                begin
                    cfg_x0_reg <= cfg_x0_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        cfg_s.x0       = cfg_x0_reg;
        cfg_s.y0       = cfg_y0_reg;
        cfg_s.x1       = cfg_x1_reg;
        cfg_s.y1       = cfg_y1_reg;
        cfg_s.max_dist = cfg_dist_reg;
        cfg_s.eff_bins = (cfg_bins_reg > MAX_BINS) ? BIN_W'(MAX_BINS) : cfg_bins_reg;
    end

    epcc_front u_front (
        .cfg      (cfg_s),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_push_entry)
    );

    epcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .entry      (q_entry)
    );

    epcc_back #(
        .MAX_BINS (MAX_BINS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_s),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("item pushed into a full queue");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:1] <= MAX_BINS))
        else $error("occupied bin count exceeds the bin map size");

    a_coverage_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] ==
            (((BIN_W+2)'(m_tdata[OUT_DATA_W-1:1]) * (BIN_W+2)'(COV_NUM))
             > ((BIN_W+2)'(cfg_s.eff_bins) * (BIN_W+2)'(COV_DEN)))))
        else $error("coverage flag disagrees with occupied bin count");
`endif

endmodule

`default_nettype wire
